### design/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared widths, constants, cell data types and CORDIC helpers for the
// tilt-compensated heading pipeline.
// ----------------------------------------------------------------------------
package thc_pkg;

   localparam int CORDIC_STAGES = 16;   // 8 .. 24
   localparam int CORDIC_MAX    = 24;
   localparam int STAGE_W       = 5;
   localparam int SQRT_BITS     = 24;
   localparam int SQ_REM_W      = 2 * SQRT_BITS;
   localparam int DIV_BITS      = 34;
   localparam int DIV_REM_W     = 32;
   localparam int HW            = 52;   // vectoring datapath
   localparam int ZW            = 26;   // angle, 1/65536 degree
   localparam int RW            = 33;   // Q2.30 rotation datapath
   localparam int IN_W          = 16;
   localparam int TILT_W        = 15;
   localparam int HEAD_W        = 16;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 15;

   localparam logic signed [ZW-1:0] DEG90    = 26'sd5898240;
   localparam logic signed [ZW-1:0] DEG180   = 26'sd11796480;
   localparam logic signed [RW-1:0] INV_GAIN = 33'sd652032874;
   localparam logic signed [RW:0]   ONE_Q30  = 34'sd1073741824;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LIMIT = 4'd1;

   typedef struct packed {
      logic signed [HW-1:0] x;
      logic signed [HW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } vec_type;

   typedef struct packed {
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQRT_BITS-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic [DIV_BITS-1:0]  num;
      logic [DIV_BITS-1:0]  quo;
      logic                 neg;
      logic [DIV_REM_W-1:0] den;
   } div_type;

   // arctan(2^-i) in 1/65536 degree
   function automatic logic signed [ZW-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // atan2(y, x) pre-rotation into the right half plane
   function automatic vec_type vec_pre(input logic signed [HW-1:0] y,
                                       input logic signed [HW-1:0] x);
      vec_type r;
      r.zero = (x == '0) && (y == '0);
      r.x    = x;
      r.y    = y;
      r.z    = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.z = DEG90;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -DEG90;
         end
      end
      return r;
   endfunction

endpackage

### design/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// Tilt-compensated compass heading: gravity + magnetic vector in, heading,
// tilt angle and trust flag out.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while req_ready is high, and results come
// out in order. The datapath is one long row of registered cells: 24
// square-root cells, three CORDIC chains (tilt atan2, sin/cos, heading
// atan2) and five parallel 34-cell divider chains for the rotation matrix.
// The whole row advances together; an output register plus one skid entry
// let the block keep taking items while a finished result waits, and
// req_ready drops only once the skid entry is occupied. The csr port is
// always ready; write it only while the pipeline is empty. Angles out are
// in 1/128 degree.
// ----------------------------------------------------------------------------
module tilt_compensated_heading import thc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input items
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [IN_W-1:0]   req_accel_x,
   input  logic signed [IN_W-1:0]   req_accel_y,
   input  logic signed [IN_W-1:0]   req_accel_z,
   input  logic signed [IN_W-1:0]   req_mag_x,
   input  logic signed [IN_W-1:0]   req_mag_y,
   input  logic signed [IN_W-1:0]   req_mag_z,
   // result items
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [HEAD_W-1:0]        rsp_heading,
   output logic [TILT_W-1:0]        rsp_tilt_angle,
   output logic                     rsp_heading_trusted,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   // pipeline stage map
   localparam int S_R2   = 1;
   localparam int S_SQ0  = S_R2 + 1;
   localparam int S_PRE1 = S_SQ0 + SQRT_BITS;
   localparam int S_V1   = S_PRE1 + 1;
   localparam int S_FOLD = S_V1 + CORDIC_STAGES;
   localparam int S_ROT  = S_FOLD + 1;
   localparam int S_CF   = S_ROT + CORDIC_STAGES;
   localparam int S_MUL  = S_CF + 1;
   localparam int S_DIV  = S_MUL + 1;
   localparam int S_MAT  = S_DIV + DIV_BITS;
   localparam int S_HM   = S_MAT + 1;
   localparam int S_PRE2 = S_HM + 1;
   localparam int S_V2   = S_PRE2 + 1;
   localparam int LAT    = S_V2 + CORDIC_STAGES;

   // divider lanes
   localparam int NDIV = 5;
   localparam int DV_A = 0;
   localparam int DV_B = 1;
   localparam int DV_D = 2;
   localparam int DV_E = 3;
   localparam int DV_F = 4;

   localparam int MW = 36;   // matrix entry width

   typedef struct packed {
      logic signed [IN_W-1:0]   kx;
      logic signed [IN_W-1:0]   ky;
      logic signed [IN_W-1:0]   kz;
      logic signed [IN_W-1:0]   bx;
      logic signed [IN_W-1:0]   by;
      logic signed [IN_W-1:0]   bz;
      logic [31:0]              r2;
      logic                     rzero;
      logic [SQRT_BITS-1:0]     r256;
      logic [TILT_W-1:0]        tilt;
      logic                     flip;
      logic signed [RW-1:0]     c;
      logic signed [RW-1:0]     s;
      logic signed [RW:0]       u;
      logic signed [31:0]       kxx;
      logic signed [31:0]       kyy;
      logic signed [31:0]       kxy;
   } carry_type;

   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic [TILT_W-1:0] tilt;
      logic              trusted;
   } out_type;

   // ---------------------------------------------------------------- control
   logic en;
   logic accept;
   logic vld_ff [0:LAT-1];

   logic     out_v_ff, skid_v_ff;
   out_type  out_ff, skid_ff, p_res;
   logic     p_valid, take;

   // the whole row moves whenever the skid entry is free
   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign accept    = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= accept;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------ config regs
   logic signed [CSR_DATA_W-1:0] dev_ff;
   logic [TILT_W-1:0]            lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= '0;
         lim_ff <= 15'd1920;   // 15 degrees
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEVIATION:  dev_ff <= $signed(csr_wdata);
            CSR_TILT_LIMIT: lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- cell buses
   sqrt_type sq_bus [0:SQRT_BITS];
   vec_type  v1_bus [0:CORDIC_STAGES];
   rot_type  rt_bus [0:CORDIC_STAGES];
   vec_type  v2_bus [0:CORDIC_STAGES];
   div_type  dv_bus [0:NDIV-1][0:DIV_BITS];
   div_type  div_in [0:NDIV-1];

   vec_type  pre1_ff, pre2_ff;
   rot_type  rot_init_ff;

   logic signed [63:0]   nums_ff [0:NDIV-1];
   logic signed [63:0]   nums_in [0:NDIV-1];
   logic signed [MW-1:0] a_ff, b_ff, d_ff, e_ff, f_ff;
   logic signed [MW-1:0] a_in, b_in, d_in, e_in, f_in;
   logic signed [HW-1:0] hx_ff, hy_ff;
   logic signed [53:0]   hx_w, hy_w;

   carry_type car_ff [0:LAT-1];
   carry_type car_in [0:LAT-1];

   // --------------------------------------------------------- side payload
   logic signed [31:0]   sxx, syy;
   logic signed [ZW-1:0] zq, q, qr;
   logic signed [ZW-1:0] qrnd;
   logic signed [RW-1:0] cval;
   rot_type              rot_init_in;

   always_comb begin
      car_in[0]    = '0;
      car_in[0].kx = req_accel_x;
      car_in[0].ky = req_accel_y;
      car_in[0].kz = req_accel_z;
      car_in[0].bx = req_mag_x;
      car_in[0].by = req_mag_y;
      car_in[0].bz = req_mag_z;
      for (int k = 1; k < LAT; k++) begin
         car_in[k] = car_ff[k-1];
      end

      // radius squared
      sxx = car_ff[S_R2-1].kx * car_ff[S_R2-1].kx;
      syy = car_ff[S_R2-1].ky * car_ff[S_R2-1].ky;
      car_in[S_R2].r2    = $unsigned(sxx) + $unsigned(syy);
      car_in[S_R2].rzero = (car_ff[S_R2-1].kx == '0) && (car_ff[S_R2-1].ky == '0);

      car_in[S_PRE1].r256 = sq_bus[SQRT_BITS].root;

      // tilt: clamp to [0, 180] degrees, fold above 90
      zq = v1_bus[CORDIC_STAGES].zero ? '0 : v1_bus[CORDIC_STAGES].z;
      if (zq < 0) begin
         q = '0;
      end else if (zq > DEG180) begin
         q = DEG180;
      end else begin
         q = zq;
      end
      qr   = (q > DEG90) ? (DEG180 - q) : q;
      qrnd = (q + 26'sd256) >>> 9;
      car_in[S_FOLD].flip = q > DEG90;
      car_in[S_FOLD].tilt = qrnd[TILT_W-1:0];
      rot_init_in.x = INV_GAIN;
      rot_init_in.y = '0;
      rot_init_in.z = qr;

      // cos sign fix, 1 - cos, square terms for the matrix
      cval = car_ff[S_CF-1].flip ? -rt_bus[CORDIC_STAGES].x : rt_bus[CORDIC_STAGES].x;
      car_in[S_CF].c   = cval;
      car_in[S_CF].s   = rt_bus[CORDIC_STAGES].y;
      car_in[S_CF].u   = ONE_Q30 - (RW+1)'(cval);
      car_in[S_CF].kxx = car_ff[S_CF-1].kx * car_ff[S_CF-1].kx;
      car_in[S_CF].kyy = car_ff[S_CF-1].ky * car_ff[S_CF-1].ky;
      car_in[S_CF].kxy = car_ff[S_CF-1].kx * car_ff[S_CF-1].ky;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LAT; k++) begin
            car_ff[k] <= car_in[k];
         end
         rot_init_ff <= rot_init_in;
      end
   end

   // ------------------------------------------------------------ square root
   assign sq_bus[0].rem  = SQ_REM_W'(car_ff[S_R2].r2) << 16;
   assign sq_bus[0].root = '0;

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
      thc_sqrt_cell u_cell (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(SQRT_BITS - 1 - j)),
         .din   (sq_bus[j]),
         .dout  (sq_bus[j+1])
      );
   end

   // --------------------------------------------- tilt atan2(r256, kz*256)
   always_ff @(posedge clock) begin
      if (en) begin
         pre1_ff <= vec_pre($signed(HW'(sq_bus[SQRT_BITS].root)),
                            $signed(HW'(car_ff[S_PRE1-1].kz)) <<< 8);
      end
   end

   assign v1_bus[0] = pre1_ff;
   assign rt_bus[0] = rot_init_ff;
   assign v2_bus[0] = pre2_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      thc_vec_cell u_v1 (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(i)),
         .din   (v1_bus[i]),
         .dout  (v1_bus[i+1])
      );
      thc_rot_cell u_rot (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(i)),
         .din   (rt_bus[i]),
         .dout  (rt_bus[i+1])
      );
      thc_vec_cell u_v2 (
         .clock (clock),
         .en    (en),
         .stage (STAGE_W'(i)),
         .din   (v2_bus[i]),
         .dout  (v2_bus[i+1])
      );
   end

   // ------------------------------------------------ matrix numerators
   always_comb begin
      nums_in[DV_A] = car_ff[S_CF].u * car_ff[S_CF].kyy;
      nums_in[DV_D] = car_ff[S_CF].u * car_ff[S_CF].kxx;
      nums_in[DV_B] = car_ff[S_CF].u * car_ff[S_CF].kxy;
      nums_in[DV_E] = (car_ff[S_CF].s * car_ff[S_CF].kx) <<< 8;
      nums_in[DV_F] = (car_ff[S_CF].s * car_ff[S_CF].ky) <<< 8;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NDIV; j++) begin
            nums_ff[j] <= nums_in[j];
         end
      end
   end

   // ------------------------------------------------------------- dividers
   // quotients stay below 2^34, so the top numerator bits start as remainder
   logic [63:0] mag [0:NDIV-1];

   always_comb begin
      for (int j = 0; j < NDIV; j++) begin
         mag[j]          = nums_ff[j][63] ? 64'(-nums_ff[j]) : 64'(nums_ff[j]);
         div_in[j].rem   = DIV_REM_W'(mag[j][63:DIV_BITS]);
         div_in[j].num   = mag[j][DIV_BITS-1:0];
         div_in[j].quo   = '0;
         div_in[j].neg   = nums_ff[j][63];
         div_in[j].den   = (j < DV_E) ? car_ff[S_MUL].r2
                                      : DIV_REM_W'(car_ff[S_MUL].r256);
      end
   end

   for (genvar j = 0; j < NDIV; j++) begin : g_div_lane
      assign dv_bus[j][0] = div_in[j];
      for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
         thc_div_cell u_cell (
            .clock (clock),
            .en    (en),
            .din   (dv_bus[j][i]),
            .dout  (dv_bus[j][i+1])
         );
      end
   end

   // --------------------------------------------------------- rotation matrix
   logic signed [DIV_BITS:0] qv [0:NDIV-1];
   logic signed [MW-1:0]     cm;

   always_comb begin
      for (int j = 0; j < NDIV; j++) begin
         qv[j] = dv_bus[j][DIV_BITS].neg ? -$signed({1'b0, dv_bus[j][DIV_BITS].quo})
                                         :  $signed({1'b0, dv_bus[j][DIV_BITS].quo});
      end
      cm = MW'(car_ff[S_MAT-1].c);
      if (car_ff[S_MAT-1].rzero) begin
         // vertical gravity: identity, no rotation
         a_in = MW'(ONE_Q30);
         d_in = MW'(ONE_Q30);
         b_in = '0;
         e_in = '0;
         f_in = '0;
      end else begin
         a_in = cm + MW'(qv[DV_A]);
         d_in = cm + MW'(qv[DV_D]);
         b_in = -MW'(qv[DV_B]);
         e_in = -MW'(qv[DV_E]);
         f_in = MW'(qv[DV_F]);
      end
   end

   always_comb begin
      hx_w = car_ff[S_MAT].bx * a_ff + car_ff[S_MAT].by * b_ff + car_ff[S_MAT].bz * e_ff;
      hy_w = car_ff[S_MAT].bx * b_ff + car_ff[S_MAT].by * d_ff - car_ff[S_MAT].bz * f_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         d_ff    <= d_in;
         e_ff    <= e_in;
         f_ff    <= f_in;
         hx_ff   <= hx_w[HW-1:0];
         hy_ff   <= hy_w[HW-1:0];
         pre2_ff <= vec_pre(hx_ff, hy_ff);   // atan2(hx, hy)
      end
   end

   // ------------------------------------------------------ heading and wrap
   logic signed [ZW-1:0] z2, zr;
   logic signed [17:0]   hs, hw;

   always_comb begin
      z2 = v2_bus[CORDIC_STAGES].zero ? '0 : v2_bus[CORDIC_STAGES].z;
      zr = (z2 + 26'sd256) >>> 9;
      // minus 90 degrees for sensor mounting, plus deviation
      hs = 18'(zr) - 18'sd11520 + 18'(dev_ff);
      if (hs < -18'sd46080) begin
         hw = hs + 18'sd92160;
      end else if (hs < 0) begin
         hw = hs + 18'sd46080;
      end else begin
         hw = hs;
      end
      p_valid       = vld_ff[LAT-1];
      p_res.heading = hw[HEAD_W-1:0];
      p_res.tilt    = car_ff[LAT-1].tilt;
      p_res.trusted = car_ff[LAT-1].tilt < lim_ff;
   end

   // --------------------------------------------------- output reg and skid
   assign take = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         // skid fills only when a new result meets a waiting one
         if (take && skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else if (en && p_valid && out_v_ff && !take) begin
            skid_v_ff <= 1'b1;
         end
         if (en && p_valid) begin
            out_v_ff <= 1'b1;
         end else if (take && !skid_v_ff) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_v_ff) begin
         out_ff <= skid_ff;
      end
      if (en && p_valid) begin
         if (out_v_ff && !take) begin
            skid_ff <= p_res;
         end else begin
            out_ff <= p_res;
         end
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_heading         = out_ff.heading;
   assign rsp_tilt_angle      = out_ff.tilt;
   assign rsp_heading_trusted = out_ff.trusted;

endmodule

### design/thc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// thc_sqrt_cell
// One result bit of the pipelined integer square root.
// ----------------------------------------------------------------------------
module thc_sqrt_cell import thc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [STAGE_W-1:0] stage,   // result bit position
   input  sqrt_type           din,
   output sqrt_type           dout
);

   logic [SQ_REM_W:0] trial;
   sqrt_type          v_in, v_ff;

   // (root + 2^p)^2 - root^2
   always_comb begin
      trial = ((SQ_REM_W+1)'(din.root) << (6'(stage) + 6'd1))
            + ((SQ_REM_W+1)'(1) << {stage, 1'b0});
      v_in = din;
      if (trial <= {1'b0, din.rem}) begin
         v_in.rem  = din.rem - trial[SQ_REM_W-1:0];
         v_in.root = din.root | (SQRT_BITS'(1) << stage);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign dout = v_ff;

endmodule

### design/thc_vec_cell.sv
// ----------------------------------------------------------------------------
// thc_vec_cell
// One CORDIC vectoring micro-rotation (atan2).
// ----------------------------------------------------------------------------
module thc_vec_cell import thc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [STAGE_W-1:0] stage,
   input  vec_type            din,
   output vec_type            dout
);

   logic signed [HW-1:0] xs, ys;
   vec_type              v_in, v_ff;

   always_comb begin
      xs   = $signed(din.x) >>> stage;
      ys   = $signed(din.y) >>> stage;
      v_in = din;
      if (din.y > 0) begin
         v_in.x = din.x + ys;
         v_in.y = din.y - xs;
         v_in.z = din.z + atan_entry(stage);
      end else begin
         v_in.x = din.x - ys;
         v_in.y = din.y + xs;
         v_in.z = din.z - atan_entry(stage);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign dout = v_ff;

endmodule

### design/thc_rot_cell.sv
// ----------------------------------------------------------------------------
// thc_rot_cell
// One CORDIC rotation-mode micro-rotation (sin/cos).
// ----------------------------------------------------------------------------
module thc_rot_cell import thc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [STAGE_W-1:0] stage,
   input  rot_type            din,
   output rot_type            dout
);

   logic signed [RW-1:0] xs, ys;
   rot_type              v_in, v_ff;

   always_comb begin
      xs   = $signed(din.x) >>> stage;
      ys   = $signed(din.y) >>> stage;
      v_in = din;
      if (din.z >= 0) begin
         v_in.x = din.x - ys;
         v_in.y = din.y + xs;
         v_in.z = din.z - atan_entry(stage);
      end else begin
         v_in.x = din.x + ys;
         v_in.y = din.y - xs;
         v_in.z = din.z + atan_entry(stage);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign dout = v_ff;

endmodule

### design/thc_div_cell.sv
// ----------------------------------------------------------------------------
// thc_div_cell
// One quotient bit of the pipelined restoring divider (magnitudes).
// ----------------------------------------------------------------------------
module thc_div_cell import thc_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  div_type din,
   output div_type dout
);

   logic [DIV_REM_W:0] rem2;
   logic [DIV_REM_W:0] diff;
   logic               ge;
   div_type            v_in, v_ff;

   always_comb begin
      rem2       = {din.rem, din.num[DIV_BITS-1]};
      diff       = rem2 - {1'b0, din.den};
      ge         = rem2 >= {1'b0, din.den};
      v_in       = din;
      v_in.rem   = ge ? diff[DIV_REM_W-1:0] : rem2[DIV_REM_W-1:0];
      v_in.num   = din.num << 1;
      v_in.quo   = {din.quo[DIV_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign dout = v_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tilt_compensated_heading: drives gravity/magnetic
// items, predicts heading, tilt and trust flag with a fixed-point model of
// the CORDIC pipeline and compares every result in order.
// ----------------------------------------------------------------------------
module tb import thc_pkg::*;;

   localparam longint ANG_DEG = 65536;
   localparam longint Q30     = 1073741824;
   localparam longint KINV    = 652032874;
   localparam longint FULL    = 46080;
   localparam int     LAT     = 3 * CORDIC_STAGES + 67;

   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic [TILT_W-1:0] tilt;
      logic              trusted;
   } heading_res_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [IN_W-1:0] req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [HEAD_W-1:0] rsp_heading;
   logic [TILT_W-1:0] rsp_tilt_angle;
   logic rsp_heading_trusted;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow registers
   longint dev_shadow;
   longint limit_shadow;

   heading_res_t expected_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always #4 clock = ~clock;

   tilt_compensated_heading dut (.*);

   // ---------------------------------------------------------------------------
   // Fixed-point predictor
   // ---------------------------------------------------------------------------
   function automatic longint asr_floor(longint v, int s);
      return v >>> s;   // arithmetic shift floors on signed
   endfunction

   function automatic longint atan_step(int i);
      longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1, 0};
      return t[i];
   endfunction

   function automatic longint cordic_atan2(longint y, longint x);
      longint z = 0, t, nx, ny;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin x = y; y = -t; z = 90 * ANG_DEG; end
         else begin x = -y; y = t; z = -90 * ANG_DEG; end
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (y > 0) begin
            nx = x + asr_floor(y, i); ny = y - asr_floor(x, i); z += atan_step(i);
         end else begin
            nx = x - asr_floor(y, i); ny = y + asr_floor(x, i); z -= atan_step(i);
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res = 0, b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin v -= res + b; res = (res >>> 1) + b; end
         else res = res >>> 1;
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic heading_res_t predict_heading(longint kx, longint ky, longint kz,
                                                    longint bx, longint by, longint bz);
      heading_res_t r;
      longint r2, r256, q, qr, x, y, z, nx, ny, c, s, u, a, b, d, e, f, hx, hy;
      longint head, tilt;
      bit flip = 0;
      r2 = kx * kx + ky * ky;
      r256 = int_sqrt(r2 << 16);
      q = cordic_atan2(r256, kz * 256);
      if (q < 0) q = 0;
      if (q > 180 * ANG_DEG) q = 180 * ANG_DEG;
      qr = q;
      if (qr > 90 * ANG_DEG) begin qr = 180 * ANG_DEG - qr; flip = 1; end
      x = KINV; y = 0; z = qr;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - asr_floor(y, i); ny = y + asr_floor(x, i); z -= atan_step(i);
         end else begin
            nx = x + asr_floor(y, i); ny = y - asr_floor(x, i); z += atan_step(i);
         end
         x = nx; y = ny;
      end
      c = flip ? -x : x;
      s = y;
      if (r2 == 0) begin
         a = Q30; d = Q30; b = 0; e = 0; f = 0;
      end else begin
         // SV division truncates toward zero, as needed here
         u = Q30 - c;
         a = c + (u * (ky * ky)) / r2;
         d = c + (u * (kx * kx)) / r2;
         b = -((u * (kx * ky)) / r2);
         e = -((s * kx * 256) / r256);
         f = (s * ky * 256) / r256;
      end
      hx = bx * a + by * b + bz * e;
      hy = bx * b + by * d - bz * f;
      head = asr_floor(cordic_atan2(hx, hy) + 256, 9) - 11520 + dev_shadow;
      head = head % FULL;
      if (head < 0) head += FULL;
      tilt = asr_floor(q + 256, 9);
      r.heading = head[HEAD_W-1:0];
      r.tilt    = tilt[TILT_W-1:0];
      r.trusted = tilt < limit_shadow;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver side
   // ---------------------------------------------------------------------------
   // valid stays up between back-to-back items; it drops only on idle cycles
   task automatic send_item(logic signed [IN_W-1:0] ax, ay, az, mx, my, mz);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax; req_accel_y <= ay; req_accel_z <= az;
      req_mag_x   <= mx; req_mag_y   <= my; req_mag_z   <= mz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // item taken at this edge
      expected_q.push_back(predict_heading(ax, ay, az, mx, my, mz));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   // only between phases, with the pipeline empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_DEVIATION)
         dev_shadow = longint'(signed'(val));
      else if (idx == CSR_TILT_LIMIT)
         limit_shadow = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int n);
      logic signed [IN_W-1:0] v[6];
      int mode;
      for (int k = 0; k < n; k++) begin
         mode = $urandom_range(9);
         foreach (v[j]) v[j] = IN_W'($urandom);
         case (mode)
            0: begin v[0] = 0; v[1] = 0; end              // vertical gravity
            1: begin                                      // small tilt, near level
               v[0] = IN_W'($signed($urandom_range(4000)) - 2000);
               v[1] = IN_W'($signed($urandom_range(4000)) - 2000);
               v[2] = 16384;
            end
            2: begin                                      // upside down
               v[0] = IN_W'($signed($urandom_range(2000)) - 1000);
               v[2] = -16384;
            end
            3: begin v[0] = IN_W'($signed($urandom_range(15)) - 8);
                     v[1] = IN_W'($signed($urandom_range(15)) - 8); end
            default: ;
         endcase
         send_item(v[0], v[1], v[2], v[3], v[4], v[5]);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      heading_res_t exp_r;
      if (!reset) begin
         rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_heading !== exp_r.heading) begin
                  $error("heading exp %0d got %0d", exp_r.heading, rsp_heading);
                  errors++;
               end
               if (rsp_tilt_angle !== exp_r.tilt) begin
                  $error("tilt_angle exp %0d got %0d", exp_r.tilt, rsp_tilt_angle);
                  errors++;
               end
               if (rsp_heading_trusted !== exp_r.trusted) begin
                  $error("heading_trusted exp %0d got %0d", exp_r.trusted,
                         rsp_heading_trusted);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_directed();
      send_idle_pct = 0; recv_stall_pct = 0;
      send_item(0, 0, 0, 0, 0, 0);                   // all zero
      send_item(0, 0, 16384, 1000, 0, 0);            // level, vertical gravity
      send_item(0, 0, -16384, 0, 1000, 500);         // inverted
      send_item(32767, 32767, 32767, 32767, 32767, 32767);
      send_item(-32768, -32768, -32768, -32768, -32768, -32768);
      send_item(-32768, 0, 0, 0, -32768, 32767);     // tilt 90
      send_item(0, 32767, -1, 100, -100, 0);
      send_item(1, 0, 32767, -500, 300, 200);        // tiny tilt
      send_item(0, -1, -32768, 300, 300, -300);
      send_item(16384, 0, 16384, 0, 0, 0);           // zero field
      send_item(-1, -1, -1, -1, -1, -1);
      send_item(32767, -32768, 0, 0, 32767, -32768);
      send_item(3000, -2000, 16000, -20000, 12000, 9000);
      send_item(0, 0, 16384, -1000, -1000, 0);
      drain_results();
   endtask

   task automatic test_config_extremes();
      int devs[4] = '{-11520, 11520, 16383, -16384};
      int lims[4] = '{0, 23040, 32767, 1};
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_DEVIATION, CSR_DATA_W'(devs[p]));
         write_reg(CSR_TILT_LIMIT, CSR_DATA_W'(lims[p]));
         write_reg(4'd7, 15'h5a5a);                 // unmapped index, ignored
         send_item(0, 0, 0, 0, 0, 0);
         send_item(0, 0, 16384, 0, 1000, 0);
         send_item(0, 0, -16384, 500, 0, 0);
         send_random(20);
         drain_results();
      end
      write_reg(CSR_DEVIATION, 15'd0);
      write_reg(CSR_TILT_LIMIT, 15'd1920);
   endtask

   task automatic test_random_idling();
      int sp[4] = '{0, 54, 0, 37};
      int rp[4] = '{0, 0, 54, 37};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = sp[p]; recv_stall_pct = rp[p];
         send_random(150);
         if (p == 1) begin
            // hold off until every expected result has come back
            req_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
            send_random(40);
         end
      end
      send_idle_pct = 0; recv_stall_pct = 0;
      drain_results();
   endtask

   task automatic test_random_config();
      for (int p = 0; p < 3; p++) begin
         write_reg(CSR_DEVIATION, CSR_DATA_W'($urandom_range(23040) - 11520));
         write_reg(CSR_TILT_LIMIT, CSR_DATA_W'($urandom_range(23040)));
         send_idle_pct = 20; recv_stall_pct = 20;
         send_random(30);
         drain_results();
      end
   endtask

   initial begin
      dev_shadow   = 0;
      limit_shadow = 1920;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_idling();
      test_random_config();
      if (errors == 0)
         $display("PASS tilt_compensated_heading");
      else
         $display("FAIL tilt_compensated_heading");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL tilt_compensated_heading");
      $finish;
   end

endmodule

### files.f
design/thc_pkg.sv
design/thc_sqrt_cell.sv
design/thc_vec_cell.sv
design/thc_rot_cell.sv
design/thc_div_cell.sv
design/tilt_compensated_heading.sv
tb/sv/tb.sv
